// ===== src/set_assoc_lru_cache_tags_assert.svh =====
// assertion macros for the lru cache tag store checker
// no dependencies; included by the checker file
`ifndef SET_ASSOC_LRU_CACHE_TAGS_ASSERT_SVH
`define SET_ASSOC_LRU_CACHE_TAGS_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define SALC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("salc: same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define SALC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("salc: next-cycle check failed");

`endif

// ===== src/salc_pkg.sv =====
// shared types and constants of the lru cache tag store
// no dependencies; used by the top level and the checker
package salc_pkg;

    localparam int MAX_INDEX_BITS_DEF = 10;
    localparam int WAYS_DEF           = 8;

    localparam int ADDR_W     = 64;
    localparam int TAG_W      = 64;
    localparam int RANK_W     = 3;
    localparam int TOTAL_W    = 32;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int SET_BITS_W = 4;
    localparam int OFF_BITS_W = 6;
    localparam int WAYS_CFG_W = 4;

    localparam logic [RANK_W-1:0] RANK_MAX = 3'd7;

    // access kinds
    localparam logic [KIND_W-1:0] KIND_LOAD_STORE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MODIFY     = 2'd1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SET_INDEX_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_OFFSET_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE       = 2'd2;

    localparam logic [SET_BITS_W-1:0] SET_BITS_RST = 4'd4;
    localparam logic [OFF_BITS_W-1:0] OFF_BITS_RST = 6'd4;
    localparam logic [WAYS_CFG_W-1:0] WAYS_CFG_RST = 4'd1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_UPDATE
    } t_state;

    function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
        return (v == '1) ? v : v + TOTAL_W'(1);
    endfunction

endpackage

// ===== src/salc_row_ram.sv =====
// one-port-write, one-port-read row memory with registered read data
// no dependencies; holds one cache set per row
module salc_row_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);
    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/set_assoc_lru_cache_tags.sv =====
// tag store of a set-associative cache with lru replacement (top level)
// depends on salc_pkg and salc_row_ram
//
// usage
//   command channel: present i_kind and i_address with start high; the word is
//   taken at a rising edge where start is high and busy is low. kind 0 is one
//   access, kind 1 (modify) is two accesses with two results, kinds 2 and 3
//   are taken and dropped with no result and leave busy low.
//   result channel: o_valid is high for exactly one cycle per access, with
//   o_hit, o_evicted, o_last and the saturating totals. the receiver cannot
//   stall; each result word is gone after its cycle.
//   config channel: i_cfg_valid / o_cfg_ready (always ready), i_cfg_index
//   0..2 picks set_index_bits, block_offset_bits, ways_in_use; index 3 is
//   dropped. write only while busy is low and no result is pending.
// sequence
//   one access = a row read, a scan of the ways and a write-back; the scan
//   stops at the hit way, or runs through the ways in use on a miss, as the
//   single tag comparator walks one way per cycle. the result word is
//   registered from the write-back. a modify's second access always hits
//   the way the first touched. busy is low while the last result strobes,
//   so a new word can be taken while it strobes.
// reset
//   synchronous, active low. afterwards a clearing pass writes all
//   2**MAX_INDEX_BITS set rows (1024 by default) invalid with busy high.
module set_assoc_lru_cache_tags
    import salc_pkg::*;
#(
    parameter int MAX_INDEX_BITS = MAX_INDEX_BITS_DEF,
    parameter int WAYS           = WAYS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // command channel
    input  logic                  start,
    output logic                  busy,
    input  logic [KIND_W-1:0]     i_kind,
    input  logic [ADDR_W-1:0]     i_address,
    // result channel
    output logic                  o_valid,
    output logic                  o_hit,
    output logic                  o_evicted,
    output logic                  o_last,
    output logic [TOTAL_W-1:0]    o_hit_total,
    output logic [TOTAL_W-1:0]    o_miss_total,
    output logic [TOTAL_W-1:0]    o_eviction_total,
    // config channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int SET_W  = (MAX_INDEX_BITS > 0) ? MAX_INDEX_BITS : 1;
    localparam int SETS   = 1 << MAX_INDEX_BITS;
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WCNT_W = $clog2(WAYS + 1);
    localparam int ROW_W  = WAYS * (1 + RANK_W + TAG_W);

    // config registers
    logic [SET_BITS_W-1:0] r_set_bits;
    logic [OFF_BITS_W-1:0] r_off_bits;
    logic [WAYS_CFG_W-1:0] r_ways_cfg;

    // sequencer
    t_state r_state, n_state;
    logic [SET_W-1:0] r_clr;

    // current access
    logic [SET_W-1:0]  r_set;
    logic [TAG_W-1:0]  r_tag;
    logic              r_modify;
    logic              r_second;

    // scan results
    logic [WCNT_W-1:0] r_way;
    logic              r_hit;
    logic [WAY_W-1:0]  r_touched;
    logic [RANK_W-1:0] r_old_rank;
    logic              r_inv_found;
    logic [WAY_W-1:0]  r_inv;
    logic [WAY_W-1:0]  r_best;
    logic [RANK_W-1:0] r_best_rank;

    // totals and result word
    logic [TOTAL_W-1:0] r_hits, r_misses, r_evicts;
    logic               r_valid, r_hit_o, r_evicted_o, r_last_o;

    // effective config
    logic [4:0]        sbits;
    logic [4:0]        ways5;
    logic [WCNT_W-1:0] n_ways;
    logic [6:0]        tag_shift;
    logic [SET_W-1:0]  set_mask;
    logic [ADDR_W-1:0] addr_shr;
    logic [SET_W-1:0]  set_calc;
    logic [TAG_W-1:0]  tag_calc;
    logic              take;

    // row memory interface
    logic              ram_we, ram_re;
    logic [SET_W-1:0]  ram_waddr;
    logic [ROW_W-1:0]  ram_wdata, ram_rdata;
    logic [WAYS-1:0]             rd_valid, wr_valid;
    logic [WAYS-1:0][RANK_W-1:0] rd_rank, wr_rank;
    logic [WAYS-1:0][TAG_W-1:0]  rd_tag, wr_tag;

    // shared comparator path
    logic [WAY_W-1:0]  way_sel;
    logic              s_valid, s_match, scan_last;
    logic [RANK_W-1:0] s_rank;

    // write-back path
    logic [WAY_W-1:0]  upd_way;
    logic              upd_evict;
    logic              upd_last;

    // ---------------------------------------------------------------
    // address split: set index clamps to MAX_INDEX_BITS, tag shift may
    // run past the top of the address and then gives zero
    // ---------------------------------------------------------------
    always_comb begin
        sbits = ({1'b0, r_set_bits} > 5'(MAX_INDEX_BITS)) ? 5'(MAX_INDEX_BITS)
                                                           : {1'b0, r_set_bits};
        ways5 = {1'b0, r_ways_cfg};
        if (ways5 == 5'd0) begin
            n_ways = WCNT_W'(1);
        end else if (ways5 > 5'(WAYS)) begin
            n_ways = WCNT_W'(WAYS);
        end else begin
            n_ways = WCNT_W'(ways5);
        end
        tag_shift = 7'(r_off_bits) + 7'(sbits);
        for (int j = 0; j < SET_W; j++) begin
            set_mask[j] = (5'(j) < sbits);
        end
        addr_shr = i_address >> r_off_bits;
        set_calc = addr_shr[SET_W-1:0] & set_mask;
        tag_calc = tag_shift[6] ? '0 : (i_address >> tag_shift[5:0]);
    end

    assign take = start && !busy
                  && (i_kind == KIND_LOAD_STORE || i_kind == KIND_MODIFY);

    // ---------------------------------------------------------------
    // row memory: one set per row, ways side by side
    // ---------------------------------------------------------------
    salc_row_ram #(
        .DATA_W (ROW_W),
        .ADDR_W (SET_W)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_set),
        .o_rdata (ram_rdata)
    );

    assign {rd_valid, rd_rank, rd_tag} = ram_rdata;

    // ---------------------------------------------------------------
    // one way per scan cycle through the shared tag comparator
    // ---------------------------------------------------------------
    always_comb begin
        way_sel   = r_way[WAY_W-1:0];
        s_valid   = rd_valid[way_sel];
        s_rank    = rd_rank[way_sel];
        s_match   = s_valid && (rd_tag[way_sel] == r_tag);
        scan_last = ((r_way + WCNT_W'(1)) == n_ways);
    end

    // ---------------------------------------------------------------
    // write-back row: touched way becomes most recent, the others in use
    // age by one (on a hit only those more recent than the hit way)
    // ---------------------------------------------------------------
    always_comb begin
        upd_evict = !r_hit && !r_inv_found;
        if (r_hit) begin
            upd_way = r_touched;
        end else if (r_inv_found) begin
            upd_way = r_inv;
        end else begin
            upd_way = r_best;
        end
        upd_last = !(r_modify && !r_second);
        for (int w = 0; w < WAYS; w++) begin
            wr_valid[w] = rd_valid[w];
            wr_tag[w]   = rd_tag[w];
            wr_rank[w]  = rd_rank[w];
            if (WAY_W'(w) == upd_way) begin
                wr_valid[w] = 1'b1;
                wr_tag[w]   = r_tag;
                wr_rank[w]  = '0;
            end else if ((WCNT_W'(w) < n_ways) && rd_valid[w]
                         && (!r_hit || rd_rank[w] < r_old_rank)
                         && (rd_rank[w] != RANK_MAX)) begin
                wr_rank[w] = rd_rank[w] + RANK_W'(1);
            end
        end
    end

    // ---------------------------------------------------------------
    // sequencer: next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == SET_W'(SETS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (take) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (s_match || scan_last) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                n_state = upd_last ? ST_IDLE : ST_READ;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // sequencer: outputs
    // ---------------------------------------------------------------
    always_comb begin
        busy      = 1'b1;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = r_set;
        ram_wdata = {wr_valid, wr_rank, wr_tag};
        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
            end
            ST_IDLE: begin
                busy = 1'b0;
            end
            ST_READ: begin
                ram_re = 1'b1;
            end
            ST_SCAN: begin
                ram_we = 1'b0;
            end
            ST_UPDATE: begin
                ram_we = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // control registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr      <= '0;
            r_valid    <= 1'b0;
            r_hits     <= '0;
            r_misses   <= '0;
            r_evicts   <= '0;
            r_set_bits <= SET_BITS_RST;
            r_off_bits <= OFF_BITS_RST;
            r_ways_cfg <= WAYS_CFG_RST;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == ST_UPDATE);
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + SET_W'(1);
            end
            if (r_state == ST_UPDATE) begin
                if (r_hit) begin
                    r_hits <= sat_inc(r_hits);
                end else begin
                    r_misses <= sat_inc(r_misses);
                    if (upd_evict) begin
                        r_evicts <= sat_inc(r_evicts);
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SET_INDEX_BITS:    r_set_bits <= i_cfg_data[SET_BITS_W-1:0];
                    CFG_BLOCK_OFFSET_BITS: r_off_bits <= i_cfg_data[OFF_BITS_W-1:0];
                    CFG_WAYS_IN_USE:       r_ways_cfg <= i_cfg_data[WAYS_CFG_W-1:0];
                    default: begin
                        r_set_bits <= r_set_bits;
                    end
                endcase
            end
        end
    end

    // ---------------------------------------------------------------
    // access and scan registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_set    <= set_calc;
            r_tag    <= tag_calc;
            r_modify <= (i_kind == KIND_MODIFY);
            r_second <= 1'b0;
        end
        if (r_state == ST_READ) begin
            r_way       <= '0;
            r_hit       <= 1'b0;
            r_inv_found <= 1'b0;
        end
        if (r_state == ST_SCAN) begin
            r_way <= r_way + WCNT_W'(1);
            if (s_match) begin
                r_hit      <= 1'b1;
                r_touched  <= way_sel;
                r_old_rank <= s_rank;
            end else begin
                // first free way, else oldest valid way (lowest on a tie)
                if (!s_valid && !r_inv_found) begin
                    r_inv_found <= 1'b1;
                    r_inv       <= way_sel;
                end
                if (r_way == '0 || s_rank > r_best_rank) begin
                    r_best      <= way_sel;
                    r_best_rank <= s_rank;
                end
            end
        end
        if (r_state == ST_UPDATE) begin
            r_second    <= 1'b1;
            r_hit_o     <= r_hit;
            r_evicted_o <= upd_evict;
            r_last_o    <= upd_last;
        end
    end

    assign o_valid          = r_valid;
    assign o_hit            = r_hit_o;
    assign o_evicted        = r_evicted_o;
    assign o_last           = r_last_o;
    assign o_hit_total      = r_hits;
    assign o_miss_total     = r_misses;
    assign o_eviction_total = r_evicts;
    assign o_cfg_ready      = 1'b1;

endmodule

// ===== src/salc_checker.sv =====
// port-level checks of the lru cache tag store, bound to the top level
// depends on salc_pkg and set_assoc_lru_cache_tags_assert.svh
`include "set_assoc_lru_cache_tags_assert.svh"

module salc_checker
    import salc_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic [KIND_W-1:0]  i_kind,
    input logic               o_valid,
    input logic               o_hit,
    input logic               o_evicted,
    input logic [TOTAL_W-1:0] o_hit_total,
    input logic [TOTAL_W-1:0] o_eviction_total
);

    // a data access word keeps the block busy on the next cycle
    `SALC_ASSERT_NEXT(a_take_busy, i_clk, i_rst_n, start && !busy && (i_kind == KIND_LOAD_STORE || i_kind == KIND_MODIFY), busy)

    // a result only follows a busy cycle
    `SALC_ASSERT_SAME(a_valid_after_busy, i_clk, i_rst_n, o_valid, $past(busy))

    // a hit never replaces a line
    `SALC_ASSERT_SAME(a_hit_no_evict, i_clk, i_rst_n, o_valid && o_hit, !o_evicted)

    // hit total steps by one or sits at saturation
    `SALC_ASSERT_SAME(a_hit_step, i_clk, i_rst_n, o_valid && o_hit, (o_hit_total == $past(o_hit_total) + 32'd1) || (o_hit_total == '1))

    // eviction total steps by one or sits at saturation
    `SALC_ASSERT_SAME(a_evict_step, i_clk, i_rst_n, o_valid && o_evicted, (o_eviction_total == $past(o_eviction_total) + 32'd1) || (o_eviction_total == '1))

endmodule

bind set_assoc_lru_cache_tags salc_checker u_salc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .i_kind           (i_kind),
    .o_valid          (o_valid),
    .o_hit            (o_hit),
    .o_evicted        (o_evicted),
    .o_hit_total      (o_hit_total),
    .o_eviction_total (o_eviction_total)
);
